[design/esd_pkg.sv]
package esd_pkg;

    // Pattern geometry
    localparam int MAX_PATTERN = 8;
    localparam int MIN_PATTERN = 2;
    localparam int HELD_DEPTH  = MAX_PATTERN - 1;
    localparam int CNT_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int TIME_W      = 32;
    localparam int PAT_W       = 64;

    // Configuration port geometry
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 64;
    localparam int REG_LSB     = 3;
    localparam int REG_IDX_W   = 2;

    // Register reset values
    localparam logic [LEN_W-1:0]  PATLEN_RST  = LEN_W'(3);
    localparam logic [PAT_W-1:0]  PATBYTES_RST = '0;
    localparam logic [TIME_W-1:0] TIMEOUT_RST = TIME_W'(1000000);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATLEN   = 2'd0,
        REG_PATBYTES = 2'd1,
        REG_TIMEOUT  = 2'd2
    } esd_reg_t;

    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_CHECK = 1'b1
    } esd_op_t;

    typedef enum logic {
        KIND_BYTE  = 1'b0,
        KIND_MATCH = 1'b1
    } esd_kind_t;

    // Byte window, entry 0 is the newest byte
    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] esd_window_t;
    typedef logic [HELD_DEPTH-1:0][BYTE_W-1:0]  esd_held_t;

    // Outcome of comparing the window against the pattern
    typedef struct packed {
        logic             match;
        logic [CNT_W-1:0] keep;
    } esd_scan_t;

endpackage

[design/esd_scan.sv]
module esd_scan (
    input  esd_pkg::esd_window_t            window,
    input  logic [esd_pkg::CNT_W-1:0]       held_count,
    input  logic [esd_pkg::LEN_W-1:0]       pat_len,
    input  logic [esd_pkg::PAT_W-1:0]       pattern_bytes,
    output esd_pkg::esd_scan_t              scan
);

    logic [esd_pkg::MAX_PATTERN:1] suffix_eq;
    logic [esd_pkg::LEN_W-1:0]     win_len;

    assign win_len = esd_pkg::LEN_W'(held_count) + esd_pkg::LEN_W'(1);

    // Compare each suffix of the window with the pattern prefix of the same length
    always_comb begin
        for (int c = 1; c <= esd_pkg::MAX_PATTERN; c++) begin
            suffix_eq[c] = 1'b1;
            for (int k = 0; k < c; k++) begin
                if (window[c-1-k] != pattern_bytes[8*k +: 8]) begin
                    suffix_eq[c] = 1'b0;
                end
            end
        end
    end

    // Full match and longest proper prefix left held
    always_comb begin
        scan.match = 1'b0;
        scan.keep  = '0;
        for (int c = 1; c <= esd_pkg::MAX_PATTERN; c++) begin
            if (pat_len == esd_pkg::LEN_W'(c) && win_len == pat_len) begin
                scan.match = suffix_eq[c];
            end
        end
        for (int c = 1; c < esd_pkg::MAX_PATTERN; c++) begin
            if (suffix_eq[c] && esd_pkg::LEN_W'(c) <= win_len
                && esd_pkg::LEN_W'(c) < pat_len) begin
                scan.keep = esd_pkg::CNT_W'(c);
            end
        end
    end

endmodule

[design/escape_sequence_detector.sv]
// Channel  Dir  Ports                            Content
// s_       in   tvalid tready tdata[39:0] tuser  in_byte, now_time; opcode
// m_       out  tvalid tready tdata[7:0] tuser   out_byte; kind; tlast = last
// apb      in   psel penable pwrite paddr pwdata 0x00 length, 0x08 bytes, 0x10 timeout
//
// One input transfer is taken per cycle while s_tready is high; it is held in the
// input register, then its results (up to 8) leave the result group one per cycle
// while m_tready is high. The input register is freed as soon as the result group is
// empty or sends its final result, so a stalled m_ side stalls s_ after one buffered
// item. aresetn is synchronous and active low; no clearing pass is needed.
module escape_sequence_detector (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [39:0]                       s_tdata,   // in_byte[7:0], now_time[39:8]
    input  logic                              s_tuser,   // opcode
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // out_byte[7:0]
    output logic                              m_tuser,   // kind
    output logic                              m_tlast,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [esd_pkg::APB_AW-1:0]        paddr,
    input  logic [esd_pkg::APB_DW-1:0]        pwdata,
    output logic [esd_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    // Configuration registers
    logic [esd_pkg::LEN_W-1:0]  patlen_reg;
    logic [esd_pkg::PAT_W-1:0]  patbytes_reg;
    logic [esd_pkg::TIME_W-1:0] timeout_reg;
    esd_pkg::esd_reg_t          reg_sel;
    logic                       cfg_wr;

    // Input register
    logic                       in_v_reg;
    esd_pkg::esd_op_t           in_op_reg;
    logic [esd_pkg::BYTE_W-1:0] in_byte_reg;
    logic [esd_pkg::TIME_W-1:0] in_time_reg;

    // Hold state
    esd_pkg::esd_held_t         held_reg, held_next;
    logic [esd_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [esd_pkg::TIME_W-1:0] start_reg, start_next;

    // Result group
    logic                       grp_v_reg;
    logic                       grp_match_reg;
    logic [esd_pkg::CNT_W-1:0]  grp_pos_reg;
    logic [esd_pkg::CNT_W-1:0]  grp_end_reg;
    esd_pkg::esd_window_t       grp_buf_reg;

    esd_pkg::esd_window_t       window;
    esd_pkg::esd_scan_t         scan;
    logic [esd_pkg::TIME_W-1:0] elapsed;
    logic                       len_ok;
    logic                       out_take;
    logic                       grp_last;
    logic                       grp_free;
    logic                       process;
    logic                       load;
    logic                       ld_match;
    logic [esd_pkg::CNT_W-1:0]  ld_pos;
    logic [esd_pkg::CNT_W-1:0]  ld_end;

    // APB register file
    assign pready  = 1'b1;
    assign reg_sel = esd_pkg::esd_reg_t'(paddr[esd_pkg::REG_LSB +: esd_pkg::REG_IDX_W]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            patlen_reg   <= esd_pkg::PATLEN_RST;
            patbytes_reg <= esd_pkg::PATBYTES_RST;
            timeout_reg  <= esd_pkg::TIMEOUT_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                esd_pkg::REG_PATLEN:   patlen_reg   <= pwdata[esd_pkg::LEN_W-1:0];
                esd_pkg::REG_PATBYTES: patbytes_reg <= pwdata[esd_pkg::PAT_W-1:0];
                esd_pkg::REG_TIMEOUT:  timeout_reg  <= pwdata[esd_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            esd_pkg::REG_PATLEN:   prdata = esd_pkg::APB_DW'(patlen_reg);
            esd_pkg::REG_PATBYTES: prdata = esd_pkg::APB_DW'(patbytes_reg);
            esd_pkg::REG_TIMEOUT:  prdata = esd_pkg::APB_DW'(timeout_reg);
            default:               prdata = '0;
        endcase
    end

    // Handshake between input register and result group
    assign out_take = m_tvalid && m_tready;
    assign grp_last = grp_match_reg || (grp_pos_reg == grp_end_reg);
    assign grp_free = !grp_v_reg || (out_take && grp_last);
    assign process  = in_v_reg && grp_free;
    assign s_tready = !in_v_reg || process;

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= esd_pkg::esd_op_t'(s_tuser);
            in_byte_reg <= s_tdata[7:0];
            in_time_reg <= s_tdata[39:8];
        end
    end

    // Window of held bytes plus the new byte, newest in entry 0
    assign window = {held_reg, in_byte_reg};

    esd_scan u_scan (
        .window         (window),
        .held_count     (count_reg),
        .pat_len        (patlen_reg),
        .pattern_bytes  (patbytes_reg),
        .scan           (scan)
    );

    assign elapsed = in_time_reg - start_reg;
    assign len_ok  = patlen_reg >= esd_pkg::LEN_W'(esd_pkg::MIN_PATTERN)
                     && patlen_reg <= esd_pkg::LEN_W'(esd_pkg::MAX_PATTERN);

    // Work out the new hold state and the results of one item
    always_comb begin
        held_next  = held_reg;
        count_next = count_reg;
        start_next = start_reg;
        load       = 1'b0;
        ld_match   = 1'b0;
        ld_pos     = count_reg;
        ld_end     = scan.keep;
        if (process) begin
            if (in_op_reg == esd_pkg::OP_CHECK) begin
                // flush everything held once the timeout is reached
                if (count_reg != '0 && elapsed >= timeout_reg) begin
                    load       = 1'b1;
                    ld_end     = esd_pkg::CNT_W'(1);
                    count_next = '0;
                    start_next = '0;
                end
            end else if (len_ok) begin
                if (scan.match) begin
                    load       = 1'b1;
                    ld_match   = 1'b1;
                    ld_pos     = '0;
                    ld_end     = '0;
                    count_next = '0;
                    start_next = '0;
                end else begin
                    // release bytes ahead of the kept suffix, keep the suffix
                    load       = scan.keep <= count_reg;
                    held_next  = {held_reg[esd_pkg::HELD_DEPTH-2:0], in_byte_reg};
                    count_next = scan.keep;
                    if (count_reg == '0 && scan.keep != '0) begin
                        start_next = in_time_reg;
                    end else if (scan.keep == '0) begin
                        start_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            start_reg <= '0;
        end else begin
            count_reg <= count_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

    // Result group: walk positions down from the oldest byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_v_reg <= 1'b0;
        end else if (load) begin
            grp_v_reg <= 1'b1;
        end else if (out_take && grp_last) begin
            grp_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_match_reg <= ld_match;
            grp_pos_reg   <= ld_pos;
            grp_end_reg   <= ld_end;
            grp_buf_reg   <= window;
        end else if (out_take && !grp_last) begin
            grp_pos_reg   <= grp_pos_reg - esd_pkg::CNT_W'(1);
        end
    end

    assign m_tvalid = grp_v_reg;
    assign m_tuser  = grp_match_reg ? esd_pkg::KIND_MATCH : esd_pkg::KIND_BYTE;
    assign m_tdata  = grp_match_reg ? '0 : grp_buf_reg[grp_pos_reg];
    assign m_tlast  = grp_last;

endmodule

[design/esd_checker.sv]
module esd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [7:0]                 m_tdata,
    input logic                       m_tuser,
    input logic                       m_tlast,
    input logic                       pready
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // A match stands alone and carries a zero byte
    a_match_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
        else $error("match result not a lone zero result");

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // The register port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind escape_sequence_detector esd_checker u_esd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

[tb/escape_sequence_detector_tb.sv]
`timescale 1ns / 100ps

module escape_sequence_detector_tb;
    import esd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        esd_op_t     op;
        logic [7:0]  in_byte;
        logic [31:0] now_time;
    } stream_item_t;

    typedef struct packed {
        esd_kind_t  kind;
        logic [7:0] out_byte;
        logic       last;
    } detector_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [39:0]       s_tdata = '0;    // in_byte[7:0], now_time[39:8]
    logic              s_tuser = 1'b0;  // opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;         // out_byte[7:0]
    logic              m_tuser;         // kind
    logic              m_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Stimulus and expected output streams
    stream_item_t     byte_stream_q [$];
    detector_result_t released_q [$];
    stream_item_t     in_flight;
    detector_result_t seen_result;

    // Shadow of the detector registers and hold state
    logic [3:0]  cfg_len = PATLEN_RST;
    logic [63:0] cfg_pat = PATBYTES_RST;
    logic [31:0] cfg_timeout = TIMEOUT_RST;
    logic [7:0]  held_q [0:HELD_DEPTH-1];
    int unsigned held_n = 0;
    logic [31:0] hold_t0 = '0;

    int          send_idle_pct = 22;
    int          recv_idle_pct = 81;
    int          err_count = 0;
    int          cycle_count = 0;
    logic [31:0] clock_us = '0;

    escape_sequence_detector u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Work out the bytes and match markers that one accepted transfer releases
    function automatic void predict_detector(input stream_item_t it);
        logic [7:0]       win [0:MAX_PATTERN-1];
        detector_result_t res_q [$];
        detector_result_t res;
        int unsigned      win_len, keep, cand, k, plen;
        logic [31:0]      elapsed;
        bit               hit;
        res = '0;
        plen = int'(cfg_len);
        if (it.op == OP_CHECK) begin
            // Guard timeout: flush the whole hold once the wrapped age reaches it
            elapsed = it.now_time - hold_t0;
            if (held_n != 0 && elapsed >= cfg_timeout) begin
                for (k = 0; k < held_n; k++) begin
                    res.kind = KIND_BYTE;
                    res.out_byte = held_q[k];
                    res_q.push_back(res);
                end
                held_n = 0;
                hold_t0 = '0;
            end
        end else if (plen >= MIN_PATTERN && plen <= MAX_PATTERN) begin
            for (k = 0; k < held_n; k++)
                win[k] = held_q[k];
            win[held_n] = it.in_byte;
            win_len = held_n + 1;
            hit = (win_len == plen);
            for (k = 0; k < win_len && hit; k++)
                if (win[k] != cfg_pat[8*k +: 8])
                    hit = 1'b0;
            if (hit) begin
                res.kind = KIND_MATCH;
                res.out_byte = '0;
                res_q.push_back(res);
                held_n = 0;
                hold_t0 = '0;
            end else begin
                // Keep the longest tail that could still start the pattern
                cand = (win_len < plen - 1) ? win_len : plen - 1;
                keep = 0;
                while (cand > 0 && keep == 0) begin
                    hit = 1'b1;
                    for (k = 0; k < cand; k++)
                        if (win[win_len - cand + k] != cfg_pat[8*k +: 8])
                            hit = 1'b0;
                    if (hit)
                        keep = cand;
                    else
                        cand--;
                end
                for (k = 0; k < win_len - keep; k++) begin
                    res.kind = KIND_BYTE;
                    res.out_byte = win[k];
                    res_q.push_back(res);
                end
                for (k = 0; k < keep; k++)
                    held_q[k] = win[win_len - keep + k];
                if (held_n == 0 && keep > 0)
                    hold_t0 = it.now_time;
                held_n = keep;
                if (keep == 0)
                    hold_t0 = '0;
            end
        end
        for (k = 0; k < res_q.size(); k++) begin
            res = res_q[k];
            res.last = (k == res_q.size() - 1);
            released_q.push_back(res);
        end
    endfunction

    function automatic void push_item(input esd_op_t op, input logic [7:0] b,
                                      input logic [31:0] now);
        stream_item_t it;
        it.op = op;
        it.in_byte = b;
        it.now_time = now;
        byte_stream_q.push_back(it);
    endfunction

    // Advance stream time a little; now and then jump to an arbitrary stamp
    task automatic queue_byte(input logic [7:0] b);
        clock_us += $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0)
            push_item(OP_DATA, b, $urandom);
        else
            push_item(OP_DATA, b, clock_us);
    endtask

    // Setup then access phase; the register takes the value on the access edge
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, {REG_LSB{1'b0}}});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATLEN:   cfg_len = val[3:0];
            REG_PATBYTES: cfg_pat = val;
            REG_TIMEOUT:  cfg_timeout = val[31:0];
            default: ;
        endcase
    endtask

    // Hold until every transfer has gone in and every release has come out
    task automatic wait_drained();
        do
            @(posedge aclk);
        while (byte_stream_q.size() != 0 || s_tvalid || released_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Input driver: hold data while stalled, pick the next transfer otherwise
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_detector(in_flight);
            if (!s_tvalid || s_tready) begin
                if (byte_stream_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_flight = byte_stream_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {in_flight.now_time, in_flight.in_byte};
                    s_tuser  <= in_flight.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each transfer with the oldest expected release
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (released_q.size() == 0) begin
                    $error("unexpected result: kind %0d out_byte %0h last %0d",
                           m_tuser, m_tdata, m_tlast);
                    err_count++;
                end else begin
                    seen_result = released_q.pop_front();
                    if (m_tuser !== seen_result.kind) begin
                        $error("kind: expected %0d, actual %0d", seen_result.kind, m_tuser);
                        err_count++;
                    end
                    if (m_tdata !== seen_result.out_byte) begin
                        $error("out_byte: expected %0h, actual %0h",
                               seen_result.out_byte, m_tdata);
                        err_count++;
                    end
                    if (m_tlast !== seen_result.last) begin
                        $error("last: expected %0d, actual %0d", seen_result.last, m_tlast);
                        err_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("escape_sequence_detector_tb: done, errors");
            $finish;
        end
    end

    initial begin : main_seq
        int          chunk, n_items, r, k, plen, rlen;
        logic [63:0] pat;
        logic [31:0] tmo;
        logic [7:0]  sym_a, sym_b;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset pattern of three zero bytes
        push_item(OP_DATA, 8'h00, 32'd1);
        push_item(OP_DATA, 8'h00, 32'd2);
        push_item(OP_DATA, 8'h00, 32'd3);
        wait_drained();

        // Longest all-ones pattern: overflow the hold, then a zero-timeout flush
        cfg_write(REG_PATLEN, 64'd8);
        cfg_write(REG_PATBYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_TIMEOUT, 64'd0);
        for (k = 0; k < 7; k++)
            push_item(OP_DATA, 8'hFF, 32'd10 + k);
        push_item(OP_DATA, 8'h00, 32'd20);
        push_item(OP_DATA, 8'hFF, 32'd21);
        push_item(OP_CHECK, 8'hA5, 32'd21);
        wait_drained();

        // Shortest pattern with the largest timeout, reached only by wrap-around
        cfg_write(REG_PATLEN, 64'd2);
        cfg_write(REG_PATBYTES, 64'h0000_0000_0000_4241);
        cfg_write(REG_TIMEOUT, 64'h0000_0000_FFFF_FFFF);
        push_item(OP_DATA, 8'h41, 32'd1000);
        push_item(OP_CHECK, 8'h00, 32'd999);
        push_item(OP_CHECK, 8'hFF, 32'd2000);
        push_item(OP_DATA, 8'h41, 32'd2001);
        push_item(OP_DATA, 8'h41, 32'd2002);
        push_item(OP_DATA, 8'h42, 32'd2003);
        wait_drained();

        // Shorten the pattern while bytes are held
        cfg_write(REG_PATLEN, 64'd8);
        cfg_write(REG_PATBYTES, 64'h4847_4645_4443_4241);
        cfg_write(REG_TIMEOUT, 64'd100);
        cfg_write(REG_UNUSED, 64'hDEAD_BEEF_0BAD_F00D);
        for (k = 0; k < 5; k++)
            push_item(OP_DATA, 8'(8'h41 + k), 32'd10 + k);
        wait_drained();
        cfg_write(REG_PATLEN, 64'd3);
        push_item(OP_DATA, 8'h46, 32'd20);
        push_item(OP_DATA, 8'h41, 32'hFFFF_FF00);
        push_item(OP_DATA, 8'h42, 32'hFFFF_FF01);
        wait_drained();

        // Out-of-range lengths drop data bytes but checks still flush
        cfg_write(REG_PATLEN, 64'd0);
        push_item(OP_DATA, 8'h41, 32'hFFFF_FF02);
        wait_drained();
        cfg_write(REG_PATLEN, 64'd15);
        push_item(OP_DATA, 8'h43, 32'hFFFF_FF03);
        push_item(OP_CHECK, 8'h00, 32'h0000_0050);
        wait_drained();

        // Random phase: mostly whole or partial patterns over a small alphabet
        clock_us = 32'd5000;
        for (chunk = 0; chunk < 6; chunk++) begin
            send_idle_pct = (chunk < 2) ? 22 : (chunk < 4) ? 81 : 0;
            recv_idle_pct = (chunk < 2) ? 81 : (chunk < 4) ? 22 : 0;
            plen = (chunk == 1) ? 2 : (chunk == 4) ? 8 : $urandom_range(2, 8);
            sym_a = 8'($urandom_range(0, 255));
            sym_b = 8'($urandom_range(0, 255));
            pat = {$urandom, $urandom};
            for (k = 0; k < plen; k++)
                pat[8*k +: 8] = ($urandom_range(0, 2) == 0) ? sym_b : sym_a;
            r = $urandom_range(0, 4);
            tmo = (r == 0) ? 32'd0 :
                  (r == 1) ? 32'($urandom_range(1, 30)) :
                  (r == 2) ? 32'($urandom_range(30, 400)) :
                  (r == 3) ? 32'hFFFF_FFFF : $urandom;
            cfg_write(REG_PATLEN, 64'(plen));
            cfg_write(REG_PATBYTES, pat);
            cfg_write(REG_TIMEOUT, 64'(tmo));
            if (chunk == 2)
                clock_us = 32'hFFFF_FF80;

            n_items = 0;
            while (n_items < 12) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    for (k = 0; k < plen; k++)
                        queue_byte(pat[8*k +: 8]);
                    n_items += plen;
                end else if (r < 60) begin
                    rlen = $urandom_range(1, plen - 1);
                    for (k = 0; k < rlen; k++)
                        queue_byte(pat[8*k +: 8]);
                    n_items += rlen;
                end else if (r < 82) begin
                    if ($urandom_range(0, 1) == 0)
                        queue_byte(8'($urandom_range(0, 255)));
                    else
                        queue_byte(($urandom_range(0, 1) == 0) ? sym_a : sym_b);
                    n_items++;
                end else begin
                    clock_us += $urandom_range(0, 40);
                    push_item(OP_CHECK, 8'($urandom), clock_us);
                    n_items++;
                end
            end
            wait_drained();

            // Brief spell with an illegal length; any hold left over must still age out
            if (chunk == 3) begin
                cfg_write(REG_PATLEN, ($urandom_range(0, 1) == 0) ? 64'd1 :
                                      64'($urandom_range(9, 15)));
                for (k = 0; k < 8; k++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        clock_us += $urandom_range(0, 400);
                        push_item(OP_CHECK, 8'($urandom), clock_us);
                    end else begin
                        queue_byte(8'($urandom_range(0, 255)));
                    end
                end
                wait_drained();
            end
        end

        if (err_count == 0)
            $display("escape_sequence_detector_tb: done, clean");
        else
            $display("escape_sequence_detector_tb: done, errors");
        $finish;
    end

endmodule

[escape_sequence_detector.f]
design/esd_pkg.sv
design/esd_scan.sv
design/escape_sequence_detector.sv
design/esd_checker.sv
tb/escape_sequence_detector_tb.sv
